### hdl/mmof_pkg.sv
// Package for the median / MAD outlier filter.
// Holds field widths, the MAD scale constants and the sequencer state codes.
// No dependencies.
package mmof_pkg;

    localparam int SAMPLE_W        = 48;
    localparam int CUT_W           = 49;
    localparam int IDX_W           = 6;
    localparam int DISC_W          = 4;
    localparam int SCALE_W         = 13;
    localparam int PROD_W          = SAMPLE_W + SCALE_W;
    localparam int REM_W           = 10;
    localparam int BIT_W           = 6;
    localparam int TOTAL_W         = 7;
    localparam int MAX_SAMPLES_DEF = 64;

    localparam logic [SCALE_W-1:0] MAD_NUM    = 13'd7413;
    localparam logic [REM_W:0]     MAD_DEN    = 11'd1000;
    localparam logic [TOTAL_W-1:0] RESULT_CAP = 7'd64;

    // ceil(MAD_NUM * 2^RCP_SH / MAD_DEN); (mad * MAD_RCP) >> RCP_SH is the
    // exact floor of mad * 7413 / 1000 for every 48-bit mad
    localparam int          RCP_SH  = 58;
    localparam logic [63:0] MAD_RCP = 64'd2136651778412639159;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SEL  = 4'd1;
    localparam logic [3:0] ST_MUL  = 4'd2;
    localparam logic [3:0] ST_DIV  = 4'd3;
    localparam logic [3:0] ST_CUT  = 4'd4;
    localparam logic [3:0] ST_CNT  = 4'd5;
    localparam logic [3:0] ST_ERD  = 4'd6;
    localparam logic [3:0] ST_ECHK = 4'd7;
    localparam logic [3:0] ST_EOUT = 4'd8;

endpackage

### hdl/median_mad_outlier_filter.sv
// Median / MAD outlier filter: sample store, rank selection, cutoff, emit pass.
// Depends on mmof_pkg.
//
// Usage: send one set of samples per word, mark the final one with is_last.
// The first discard_count samples of each set are dropped; the rest (up to
// MAX_SAMPLES) go into a single-port-write, registered-read sample memory.
// Loading accepts one sample per cycle. After is_last the block stalls input
// and works from the memory alone: the median and the MAD are each found by
// a bitwise radix select, 48 sweeps over the n stored samples; the cutoff
// takes a setup step, four 24x32 partial products that scale the MAD by
// 7413/1000 through a fixed reciprocal, and the saturating sum; a counting
// sweep counts the survivors, and the emit pass reads back stored samples up
// to the last survivor, sending each and holding a word while output stalls.
// All of this is bound by the one read port of the sample memory. An empty
// set costs nothing beyond its load. Survivors come out in arrival order,
// each word carrying median, MAD and cutoff; last_survivor marks the final
// word.
module median_mad_outlier_filter #(
    parameter int MAX_SAMPLES = mmof_pkg::MAX_SAMPLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [mmof_pkg::DISC_W-1:0]   cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mmof_pkg::SAMPLE_W-1:0] sample_value,
    input  logic                          is_last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mmof_pkg::SAMPLE_W-1:0] survivor_value,
    output logic [mmof_pkg::IDX_W-1:0]    survivor_index,
    output logic [mmof_pkg::SAMPLE_W-1:0] median_value,
    output logic [mmof_pkg::SAMPLE_W-1:0] mad_value,
    output logic [mmof_pkg::CUT_W-1:0]    cutoff,
    output logic                          last_survivor
);
    import mmof_pkg::*;

    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] DEPTH = CW'(MAX_SAMPLES);
    localparam int RCP_W  = 64;
    localparam int HALF_W = SAMPLE_W / 2;
    localparam int PART_W = HALF_W + RCP_W / 2;
    localparam int ACC_W  = SAMPLE_W + RCP_W;

    // sample memory
    logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                wr_en;
    logic [AW-1:0]       rd_addr;

    // control and datapath registers
    logic [3:0]          state_reg;
    logic [DISC_W-1:0]   discard_reg;
    logic [DISC_W-1:0]   seen_reg;
    logic [CW-1:0]       kept_reg;
    logic [CW-1:0]       n_reg;
    logic [CW-1:0]       rd_idx_reg;
    logic                pend_reg;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       krem_reg;
    logic [BIT_W-1:0]    bit_reg;
    logic                phase_mad_reg;
    logic [SAMPLE_W-1:0] prefix_reg;
    logic [SAMPLE_W-1:0] med_reg;
    logic [SAMPLE_W-1:0] mad_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [1:0]          step_reg;
    logic [CUT_W-1:0]    cut_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  emitted_reg;
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] surv_val_reg;
    logic [IDX_W-1:0]    surv_idx_reg;
    logic                surv_last_reg;

    logic                accept;
    logic                store_it;
    logic [CW-1:0]       kept_inc;
    logic                sweep_issue;
    logic                pass_end;
    logic [SAMPLE_W-1:0] dev;
    logic [SAMPLE_W-1:0] sel_val;
    logic [SAMPLE_W-1:0] hi_mask;
    logic                sel_hit;
    logic                new_bit;
    logic [SAMPLE_W-1:0] prefix_new;
    logic [HALF_W-1:0]   mad_part;
    logic [RCP_W/2-1:0]  rcp_part;
    logic [PART_W-1:0]   part;
    logic [ACC_W-1:0]    part_sh;
    logic [PROD_W-1:0]   cut_sum;
    logic                surv_hit;
    logic [CW+TOTAL_W-1:0] cnt_ext;
    logic [AW+IDX_W-1:0]   idx_ext;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign store_it = (seen_reg >= discard_reg) && (kept_reg < DEPTH);
    assign wr_en    = accept && store_it;
    assign kept_inc = store_it ? kept_reg + 1'b1 : kept_reg;
    assign rd_addr  = rd_idx_reg[AW-1:0];

    // sweep: one read issued per cycle, data checked in the cycle after
    assign sweep_issue = (rd_idx_reg < n_reg);
    assign pass_end    = !sweep_issue && !pend_reg;

    assign dev     = (rd_data_reg >= med_reg) ? rd_data_reg - med_reg
                                              : med_reg - rd_data_reg;
    assign sel_val = phase_mad_reg ? dev : rd_data_reg;
    assign hi_mask = ({SAMPLE_W{1'b1}} << bit_reg) << 1;
    assign sel_hit = pend_reg && (((sel_val ^ prefix_reg) & hi_mask) == '0)
                     && !sel_val[bit_reg];
    assign new_bit = !(cnt_reg > krem_reg);
    always_comb
    begin
        prefix_new          = prefix_reg;
        prefix_new[bit_reg] = new_bit;
    end

    // MAD times the scaled reciprocal of 1000/7413, one 24x32 partial product a cycle
    assign mad_part = step_reg[0] ? mad_reg[SAMPLE_W-1:HALF_W] : mad_reg[HALF_W-1:0];
    assign rcp_part = step_reg[1] ? MAD_RCP[RCP_W-1:RCP_W/2] : MAD_RCP[RCP_W/2-1:0];
    assign part     = mad_part * rcp_part;
    always_comb
    begin
        case (step_reg)
            2'd0:    part_sh = ACC_W'(part);
            2'd1:    part_sh = ACC_W'(part) << HALF_W;
            2'd2:    part_sh = ACC_W'(part) << (RCP_W / 2);
            2'd3:    part_sh = ACC_W'(part) << (HALF_W + RCP_W / 2);
            default: part_sh = '0;
        endcase
    end
    assign cut_sum = PROD_W'(med_reg) + PROD_W'(acc_reg[ACC_W-1:RCP_SH]);

    assign surv_hit = ({1'b0, rd_data_reg} <= cut_reg);
    assign cnt_ext  = {{TOTAL_W{1'b0}}, cnt_reg};
    assign idx_ext  = {{IDX_W{1'b0}}, rd_idx_reg[AW-1:0]};

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[kept_reg[AW-1:0]] <= sample_value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            discard_reg   <= '0;
            seen_reg      <= '0;
            kept_reg      <= '0;
            n_reg         <= '0;
            rd_idx_reg    <= '0;
            pend_reg      <= 1'b0;
            cnt_reg       <= '0;
            krem_reg      <= '0;
            bit_reg       <= '0;
            phase_mad_reg <= 1'b0;
            prefix_reg    <= '0;
            med_reg       <= '0;
            mad_reg       <= '0;
            acc_reg       <= '0;
            step_reg      <= '0;
            cut_reg       <= '0;
            total_reg     <= '0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
            surv_val_reg  <= '0;
            surv_idx_reg  <= '0;
            surv_last_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                discard_reg <= cfg_wr_data;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (is_last)
                        begin
                            // close the set and, if it kept any samples, start the median select
                            seen_reg      <= '0;
                            kept_reg      <= '0;
                            n_reg         <= kept_inc;
                            rd_idx_reg    <= '0;
                            pend_reg      <= 1'b0;
                            cnt_reg       <= '0;
                            krem_reg      <= kept_inc >> 1;
                            bit_reg       <= BIT_W'(SAMPLE_W - 1);
                            phase_mad_reg <= 1'b0;
                            prefix_reg    <= '0;
                            if (kept_inc != '0)
                            begin
                                state_reg <= ST_SEL;
                            end
                        end
                        else
                        begin
                            if (seen_reg < discard_reg)
                            begin
                                seen_reg <= seen_reg + 1'b1;
                            end
                            kept_reg <= kept_inc;
                        end
                    end
                end
                ST_SEL:
                begin
                    pend_reg <= sweep_issue;
                    if (sweep_issue)
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                    if (sel_hit)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (pass_end)
                    begin
                        // settle one bit of the selected value
                        rd_idx_reg <= '0;
                        cnt_reg    <= '0;
                        if (bit_reg == '0)
                        begin
                            prefix_reg <= '0;
                            bit_reg    <= BIT_W'(SAMPLE_W - 1);
                            krem_reg   <= n_reg >> 1;
                            if (!phase_mad_reg)
                            begin
                                med_reg       <= prefix_new;
                                phase_mad_reg <= 1'b1;
                            end
                            else
                            begin
                                mad_reg   <= (prefix_new == '0) ? SAMPLE_W'(1) : prefix_new;
                                state_reg <= ST_MUL;
                            end
                        end
                        else
                        begin
                            if (new_bit)
                            begin
                                krem_reg <= krem_reg - cnt_reg;
                            end
                            prefix_reg <= prefix_new;
                            bit_reg    <= bit_reg - 1'b1;
                        end
                    end
                end
                ST_MUL:
                begin
                    acc_reg   <= '0;
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    // accumulate the four partial products of mad * MAD_RCP
                    acc_reg  <= acc_reg + part_sh;
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 2'd3)
                    begin
                        state_reg <= ST_CUT;
                    end
                end
                ST_CUT:
                begin
                    cut_reg    <= (cut_sum > PROD_W'({CUT_W{1'b1}})) ? {CUT_W{1'b1}}
                                                                     : cut_sum[CUT_W-1:0];
                    rd_idx_reg <= '0;
                    pend_reg   <= 1'b0;
                    cnt_reg    <= '0;
                    state_reg  <= ST_CNT;
                end
                ST_CNT:
                begin
                    pend_reg <= sweep_issue;
                    if (sweep_issue)
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                    if (pend_reg && surv_hit)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (pass_end)
                    begin
                        total_reg   <= (cnt_ext > (CW+TOTAL_W)'(RESULT_CAP)) ? RESULT_CAP
                                                                          : cnt_ext[TOTAL_W-1:0];
                        emitted_reg <= '0;
                        rd_idx_reg  <= '0;
                        state_reg   <= (cnt_reg == '0) ? ST_IDLE : ST_ERD;
                    end
                end
                ST_ERD:
                begin
                    state_reg <= (rd_idx_reg == n_reg) ? ST_IDLE : ST_ECHK;
                end
                ST_ECHK:
                begin
                    if (surv_hit)
                    begin
                        surv_val_reg  <= rd_data_reg;
                        surv_idx_reg  <= idx_ext[IDX_W-1:0];
                        surv_last_reg <= (emitted_reg + 1'b1 == total_reg);
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_EOUT;
                    end
                    else
                    begin
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                        state_reg  <= ST_ERD;
                    end
                end
                ST_EOUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        emitted_reg   <= emitted_reg + 1'b1;
                        rd_idx_reg    <= rd_idx_reg + 1'b1;
                        state_reg     <= surv_last_reg ? ST_IDLE : ST_ERD;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign survivor_value = surv_val_reg;
    assign survivor_index = surv_idx_reg;
    assign median_value   = med_reg;
    assign mad_value      = mad_reg;
    assign cutoff         = cut_reg;
    assign last_survivor  = surv_last_reg;

    // a survivor word never lies above its own cutoff
    a_surv_below_cut: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ({1'b0, survivor_value} <= cutoff))
        else $error("survivor above cutoff");

    // the MAD shown with a word is never zero
    a_mad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (mad_value != '0))
        else $error("zero MAD on output");

    // the fill count never passes the store depth
    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= DEPTH)
        else $error("kept count beyond store depth");

    // input is held off while a word waits on the output
    a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken during emit");

endmodule

### tb/sv/median_mad_outlier_filter_checker.sv
// Checker for the median / MAD outlier filter: watches the sample, config and
// survivor channels, predicts every survivor word and compares field by field.
// Depends on mmof_pkg.
module median_mad_outlier_filter_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [mmof_pkg::DISC_W-1:0]   cfg_wr_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [mmof_pkg::SAMPLE_W-1:0] sample_value,
    input  logic                          is_last,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [mmof_pkg::SAMPLE_W-1:0] survivor_value,
    input  logic [mmof_pkg::IDX_W-1:0]    survivor_index,
    input  logic [mmof_pkg::SAMPLE_W-1:0] median_value,
    input  logic [mmof_pkg::SAMPLE_W-1:0] mad_value,
    input  logic [mmof_pkg::CUT_W-1:0]    cutoff,
    input  logic                          last_survivor,
    output int unsigned                   survivors_due,
    output int unsigned                   survivors_checked,
    output int unsigned                   fail_count
);
    import mmof_pkg::*;

    localparam int STORE_DEPTH = MAX_SAMPLES_DEF;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic [IDX_W-1:0]    index;
        logic [SAMPLE_W-1:0] median;
        logic [SAMPLE_W-1:0] mad;
        logic [CUT_W-1:0]    cut;
        logic                last;
    } survivor_t;

    survivor_t           survivor_q[$];
    logic [SAMPLE_W-1:0] kept_samples[STORE_DEPTH];
    logic [SAMPLE_W-1:0] rank_buf[STORE_DEPTH];
    logic [DISC_W-1:0]   warmup_len;
    int unsigned         warmup_seen;
    int unsigned         kept_n;

    task automatic report(input string what);
        $display("[%0t] survivor mismatch: %s", $time, what);
        fail_count++;
    endtask

    function automatic void sort_rank_buf(input int unsigned n);
        logic [SAMPLE_W-1:0] v;
        int                  j;
        for (int i = 1; i < n; i++)
        begin
            v = rank_buf[i];
            j = i;
            while (j > 0 && rank_buf[j-1] > v)
            begin
                rank_buf[j] = rank_buf[j-1];
                j--;
            end
            rank_buf[j] = v;
        end
    endfunction

    // Store one accepted sample; on the last one of a set queue its survivors.
    function automatic void absorb_sample(input logic [SAMPLE_W-1:0] v, input logic last);
        int unsigned         n;
        int unsigned         total;
        int unsigned         sent;
        logic [SAMPLE_W-1:0] med;
        logic [SAMPLE_W-1:0] mad;
        logic [63:0]         scaled;
        logic [63:0]         cut_wide;
        logic [CUT_W-1:0]    cut;
        survivor_t           s;
        if (warmup_seen < warmup_len)
            warmup_seen++;
        else if (kept_n < STORE_DEPTH)
        begin
            kept_samples[kept_n] = v;
            kept_n++;
        end
        if (!last)
            return;
        n = kept_n;
        warmup_seen = 0;
        kept_n = 0;
        if (n == 0)
            return;
        for (int i = 0; i < n; i++)
            rank_buf[i] = kept_samples[i];
        sort_rank_buf(n);
        med = rank_buf[n >> 1];
        for (int i = 0; i < n; i++)
            rank_buf[i] = (rank_buf[i] < med) ? med - rank_buf[i] : rank_buf[i] - med;
        sort_rank_buf(n);
        mad = rank_buf[n >> 1];
        if (mad == 0)
            mad = 1;
        scaled = (64'(mad) * 64'(MAD_NUM)) / 64'(MAD_DEN);
        cut_wide = 64'(med) + scaled;
        cut = (cut_wide > {15'd0, {CUT_W{1'b1}}}) ? {CUT_W{1'b1}} : cut_wide[CUT_W-1:0];
        total = 0;
        for (int i = 0; i < n; i++)
            if (kept_samples[i] <= cut)
                total++;
        if (total > RESULT_CAP)
            total = RESULT_CAP;
        sent = 0;
        for (int i = 0; i < n && sent < total; i++)
        begin
            if (kept_samples[i] <= cut)
            begin
                s.value  = kept_samples[i];
                s.index  = i[IDX_W-1:0];
                s.median = med;
                s.mad    = mad;
                s.cut    = cut;
                s.last   = (sent + 1 == total);
                survivor_q.push_back(s);
                sent++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        survivor_t s;
        if (!rst_n)
        begin
            survivor_q.delete();
            warmup_len        <= '0;
            warmup_seen       = 0;
            kept_n            = 0;
            survivors_due     <= 0;
            survivors_checked <= 0;
            fail_count        = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                survivors_checked <= survivors_checked + 1;
                if (survivor_q.size() == 0)
                    report($sformatf("unexpected word value=%0d", survivor_value));
                else
                begin
                    s = survivor_q.pop_front();
                    if (survivor_value !== s.value)
                        report($sformatf("value %0d, want %0d", survivor_value, s.value));
                    if (survivor_index !== s.index)
                        report($sformatf("index %0d, want %0d", survivor_index, s.index));
                    if (median_value !== s.median)
                        report($sformatf("median %0d, want %0d", median_value, s.median));
                    if (mad_value !== s.mad)
                        report($sformatf("mad %0d, want %0d", mad_value, s.mad));
                    if (cutoff !== s.cut)
                        report($sformatf("cutoff %0d, want %0d", cutoff, s.cut));
                    if (last_survivor !== s.last)
                        report($sformatf("last %0b, want %0b", last_survivor, s.last));
                end
            end
            if (in_valid && !in_stall)
                absorb_sample(sample_value, is_last);
            if (cfg_wr_en)
                warmup_len <= cfg_wr_data;
            survivors_due <= survivor_q.size();
        end
    end

endmodule

### tb/sv/median_mad_outlier_filter_tb.sv
// Testbench top for the median / MAD outlier filter: clock, reset, sample
// stimulus in sets, output stall pattern and the verdict.
// Depends on mmof_pkg, median_mad_outlier_filter and its checker.
module median_mad_outlier_filter_tb;
    import mmof_pkg::*;

    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};
    // Margin after the last predicted survivor; the block is idle by then.
    localparam int DRAIN_CYCLES = 400;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [DISC_W-1:0]   cfg_wr_data;
    logic                in_valid;
    logic                in_stall;
    logic [SAMPLE_W-1:0] sample_value;
    logic                is_last;
    logic                out_valid;
    logic                out_stall;
    logic [SAMPLE_W-1:0] survivor_value;
    logic [IDX_W-1:0]    survivor_index;
    logic [SAMPLE_W-1:0] median_value;
    logic [SAMPLE_W-1:0] mad_value;
    logic [CUT_W-1:0]    cutoff;
    logic                last_survivor;

    int unsigned survivors_due;
    int unsigned survivors_checked;
    int unsigned fail_count;

    int unsigned words_sent;
    int unsigned sets_sent;
    int unsigned burst_left;
    bit          hold_off_req;
    bit [15:0]   discard_seen;

    median_mad_outlier_filter uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .sample_value   (sample_value),
        .is_last        (is_last),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .survivor_value (survivor_value),
        .survivor_index (survivor_index),
        .median_value   (median_value),
        .mad_value      (mad_value),
        .cutoff         (cutoff),
        .last_survivor  (last_survivor)
    );

    median_mad_outlier_filter_checker checker_i (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .sample_value      (sample_value),
        .is_last           (is_last),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .survivor_value    (survivor_value),
        .survivor_index    (survivor_index),
        .median_value      (median_value),
        .mad_value         (mad_value),
        .cutoff            (cutoff),
        .last_survivor     (last_survivor),
        .survivors_due     (survivors_due),
        .survivors_checked (survivors_checked),
        .fail_count        (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #20_000_000;
        $display("timeout: %0d words sent, %0d survivors still due", words_sent, survivors_due);
        $display("** median_mad_outlier_filter: FAILED **");
        $finish;
    end

    // Receiver: stall on one of four randomly redrawn modes; once, on
    // request, hold off for a long stretch so the block backs up into its input.
    initial
    begin
        int unsigned mode;
        int unsigned phase_left;
        int unsigned held;
        bit          hold_done;
        mode = 0;
        phase_left = 0;
        hold_done = 1'b0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_done)
            begin
                hold_done = 1'b1;
                held = 0;
                while (held < 3000)
                begin
                    out_stall <= 1'b1;
                    held++;
                    @(posedge clk);
                end
            end
            if (phase_left == 0)
            begin
                mode = $urandom_range(0, 3);
                phase_left = 150;
            end
            phase_left--;
            case (mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 30);
                2: out_stall <= (phase_left % 5) < 3;
                default: out_stall <= ($urandom_range(0, 99) < 85);
            endcase
        end
    end

    // Present one word and hold it until accepted; keep valid high inside a
    // burst, drop it for a random gap (sometimes none) between bursts.
    task automatic send_word(input logic [SAMPLE_W-1:0] v, input logic last);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        sample_value <= v;
        is_last      <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        if (last)
            sets_sent++;
    endtask

    // Drop valid and wait until every predicted survivor has come out and the
    // emit pass has had time to finish its scan.
    task automatic drain;
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        @(posedge clk);
        while (survivors_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_discard(input logic [DISC_W-1:0] v);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        discard_seen[v] = 1'b1;
    endtask

    function automatic logic [SAMPLE_W-1:0] any_sample();
        return SAMPLE_W'({$urandom, $urandom});
    endfunction

    // One well-formed set: a cluster around a base with a few outliers.
    task automatic send_set(input int unsigned len);
        logic [SAMPLE_W-1:0] base;
        logic [SAMPLE_W-1:0] v;
        int unsigned         spread;
        base = ($urandom_range(0, 3) == 0) ? any_sample() : 48'($urandom_range(1000, 2000000));
        spread = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 5000);
        for (int i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 9))
                0: v = any_sample();
                1: v = base + 48'(spread) * 48'($urandom_range(10, 400));
                2: v = SAMPLE_MAX - 48'($urandom_range(0, 3));
                default: v = base + 48'($urandom_range(0, spread));
            endcase
            send_word(v, i == len - 1);
        end
    endtask

    initial
    begin
        int unsigned len;
        int unsigned pick;
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        in_valid     = 1'b0;
        sample_value = '0;
        is_last      = 1'b0;
        hold_off_req = 1'b0;
        words_sent   = 0;
        sets_sent    = 0;
        burst_left   = 0;
        discard_seen = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets with no warm-up: single sample (zero MAD forced to
        // one), all equal, even count with upper median, all-zero samples,
        // a far outlier that gets dropped, and a full-range pair whose
        // cutoff saturates.
        write_discard(4'd0);
        send_word(48'd500, 1'b1);
        send_word(48'd7, 1'b0);
        send_word(48'd7, 1'b0);
        send_word(48'd7, 1'b1);
        send_word(48'd40, 1'b0);
        send_word(48'd10, 1'b0);
        send_word(48'd30, 1'b0);
        send_word(48'd20, 1'b1);
        send_word(48'd0, 1'b0);
        send_word(48'd0, 1'b1);
        send_word(48'd100, 1'b0);
        send_word(48'd101, 1'b0);
        send_word(48'd99, 1'b0);
        send_word(48'd100, 1'b0);
        send_word(48'd9000000, 1'b1);
        send_word(48'd0, 1'b0);
        send_word(SAMPLE_MAX, 1'b1);

        // Warm-up longer than the set: an empty set emits nothing.
        write_discard(4'd15);
        send_word(48'd5, 1'b0);
        send_word(SAMPLE_MAX, 1'b1);
        write_discard(4'd2);
        send_word(48'd1, 1'b0);
        send_word(48'd2, 1'b0);
        send_word(48'd3, 1'b1);

        // Random sets; change warm-up between phases, often to an extreme (0 or 15).
        while (words_sent < 460)
        begin
            if (sets_sent % 9 == 0)
            begin
                pick = $urandom_range(0, 4);
                write_discard(pick == 0 ? 4'd0 : pick == 1 ? 4'd15 : 4'($urandom_range(0, 15)));
            end
            // Once: long receiver hold-off while sets keep arriving.
            if (sets_sent > 12 && !hold_off_req && words_sent > 150)
                hold_off_req = 1'b1;
            pick = $urandom_range(0, 19);
            if (pick == 0)
                len = $urandom_range(60, 80);      // overfill the store
            else if (pick < 4)
                len = $urandom_range(13, 40);
            else if (pick < 6)
                len = $urandom_range(1, 3);        // often empty after warm-up
            else
                len = $urandom_range(1, 12);
            if (pick == 19)
                for (int i = 0; i < len; i++)
                    send_word(any_sample(), $urandom_range(0, 7) == 0 || i == len - 1);
            else
                send_set(len);
        end

        drain();
        $display("covered %0d sample words in %0d sets, %0d survivor words checked",
                 words_sent, sets_sent, survivors_checked);
        $display("warm-up settings used: %0d of 16, including 0 and 15", $countones(discard_seen));
        if (survivors_due != 0)
            $display("%0d predicted survivor words never arrived", survivors_due);
        if (fail_count == 0 && survivors_due == 0)
            $display("** median_mad_outlier_filter: PASSED **");
        else
            $display("** median_mad_outlier_filter: FAILED **");
        $finish;
    end

endmodule

### files.f
hdl/mmof_pkg.sv
hdl/median_mad_outlier_filter.sv
tb/sv/median_mad_outlier_filter_checker.sv
tb/sv/median_mad_outlier_filter_tb.sv
